>>> design/pwbm_pkg.sv
// ----------------------------------------------------------------------------
// pwbm_pkg
// Shared types and codes for the periodic window byte modifier.
// ----------------------------------------------------------------------------
package pwbm_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_WINDOW_START   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_STOP    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPACING_PERIOD = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_OPERATION_MODE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OPERAND_VALUE  = 3'd4;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_XOR     = 4'd4,
    OP_AND     = 4'd5,
    OP_OR      = 4'd6,
    OP_NOT     = 4'd7,
    OP_SHL     = 4'd8,
    OP_SAR     = 4'd9,
    OP_MOD     = 4'd10,
    OP_REPLACE = 4'd11
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WB
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic write_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> design/pwbm_ctrl.sv
// ----------------------------------------------------------------------------
// pwbm_ctrl
// Sequencer: takes a request, runs the divider when needed, writes the result.
// ----------------------------------------------------------------------------
module pwbm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pwbm_pkg::sts_t sts,
  output pwbm_pkg::cmd_t cmd
);
  import pwbm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.write_out = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.need_div ? ST_DIV : ST_WB;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        // wait for the output register to drain
        if (sts.out_free) begin
          cmd.write_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/pwbm_dp.sv
// ----------------------------------------------------------------------------
// pwbm_dp
// Datapath: config registers, position and spacing counters, ALU, divider
// and the output register.
// ----------------------------------------------------------------------------
module pwbm_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [pwbm_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [pwbm_pkg::CfgDataW-1:0]   cfg_data,
  input  logic [7:0]                      data_byte,
  output logic [7:0]                      out_byte,
  output logic                            was_modified,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  pwbm_pkg::cmd_t                  cmd,
  output pwbm_pkg::sts_t                  sts
);
  import pwbm_pkg::*;

  logic [31:0] window_start;
  logic [31:0] window_stop;
  logic [15:0] spacing_period;
  logic [3:0]  op_mode;
  logic [7:0]  operand;

  logic [31:0] byte_position;
  logic [15:0] spacing_count;

  logic [7:0]  data_q;
  logic        hit_q;

  logic [7:0]  rem;
  logic [7:0]  quo;
  logic [7:0]  dvs;
  logic [2:0]  step_cnt;

  logic        hit_now;
  logic        is_div_op;
  logic [8:0]  rem_sh;
  logic        ge;
  logic [8:0]  diff;
  logic [7:0]  quot_s;
  logic [7:0]  rem_s;
  logic [7:0]  prod;
  logic [7:0]  alu_res;
  logic [7:0]  result;

  // configuration, one register per write
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start   <= '0;
      window_stop    <= '1;
      spacing_period <= '0;
      op_mode        <= OP_ADD;
      operand        <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW_START:   window_start   <= cfg_data;
        CFG_WINDOW_STOP:    window_stop    <= cfg_data;
        CFG_SPACING_PERIOD: spacing_period <= cfg_data[15:0];
        CFG_OPERATION_MODE: op_mode        <= cfg_data[3:0];
        CFG_OPERAND_VALUE:  operand        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign hit_now   = (spacing_count >= spacing_period) &&
                     (byte_position >= window_start) &&
                     (byte_position <= window_stop);
  assign is_div_op = (op_mode == OP_DIV) || (op_mode == OP_MOD);

  assign sts.need_div = hit_now && is_div_op && (operand != 8'd0);
  assign sts.div_done = (step_cnt == 3'd7);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      spacing_count <= '0;
    end else if (cmd.load) begin
      byte_position <= byte_position + 32'd1;
      spacing_count <= hit_now ? 16'd1 : spacing_count + 16'd1;
    end
  end

  // restoring divider on magnitudes, one quotient bit a cycle
  assign rem_sh = {rem, quo[7]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign ge     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_q   <= data_byte;
      hit_q    <= hit_now;
      rem      <= '0;
      quo      <= data_byte[7] ? 8'(-data_byte) : data_byte;
      dvs      <= operand[7] ? 8'(-operand) : operand;
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      rem      <= ge ? diff[7:0] : rem_sh[7:0];
      quo      <= {quo[6:0], ge};
      step_cnt <= step_cnt + 3'd1;
    end
  end

  assign quot_s = (data_q[7] ^ operand[7]) ? 8'(-quo) : quo;
  assign rem_s  = data_q[7] ? 8'(-rem) : rem;
  assign prod   = 8'(data_q * operand);

  always_comb begin
    alu_res = data_q;
    case (op_mode)
      OP_ADD:     alu_res = data_q + operand;
      OP_SUB:     alu_res = data_q - operand;
      OP_MUL:     alu_res = prod;
      OP_DIV:     alu_res = (operand == 8'd0) ? data_q : quot_s;
      OP_XOR:     alu_res = data_q ^ operand;
      OP_AND:     alu_res = data_q & operand;
      OP_OR:      alu_res = data_q | operand;
      OP_NOT:     alu_res = ~data_q;
      OP_SHL: begin
        if (operand[7]) begin
          alu_res = data_q;
        end else if (operand[6:3] != 4'd0) begin
          alu_res = '0;
        end else begin
          alu_res = data_q << operand[2:0];
        end
      end
      OP_SAR: begin
        if (operand[7]) begin
          alu_res = data_q;
        end else if (operand[6:3] != 4'd0) begin
          alu_res = {8{data_q[7]}};
        end else begin
          alu_res = 8'($signed(data_q) >>> operand[2:0]);
        end
      end
      OP_MOD:     alu_res = (operand == 8'd0) ? data_q : rem_s;
      OP_REPLACE: alu_res = operand;
      default:    alu_res = data_q;
    endcase
  end

  assign result = hit_q ? alu_res : data_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      out_byte     <= result;
      was_modified <= hit_q;
    end
  end

endmodule

>>> design/periodic_window_byte_modifier_core.sv
// ----------------------------------------------------------------------------
// periodic_window_byte_modifier_core
// Byte stream filter that applies an ALU operation to spaced bytes inside a
// position window.
// ----------------------------------------------------------------------------
// Usage:
//   input request  : data_byte with in_valid / in_ready
//   output request : out_byte, was_modified with out_valid / out_ready
//   config writes  : cfg_index / cfg_data with cfg_valid / cfg_ready, always
//                    ready; index 0 window start, 1 window stop, 2 spacing
//                    period, 3 operation mode, 4 operand
// Sequence: a taken byte is loaded, then written to the output register,
//   which raises out_valid; a division or modulo by a non-zero operand first
//   runs the divider. A new byte is taken only after the last is written;
//   the restoring divider produces one quotient bit per cycle.
// The output register holds a finished result while the next byte is taken;
//   a stalled receiver holds the block in write-back after that.
// Reset clears the position and spacing counters, sets the window to the
//   full range and the mode to add with operand zero.
// ----------------------------------------------------------------------------
module periodic_window_byte_modifier_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pwbm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pwbm_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          was_modified
);
  import pwbm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pwbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pwbm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .out_byte     (out_byte),
    .was_modified (was_modified),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
